// ===== rtl/windowed_peak_to_peak_alarm_unit_macros.svh =====
// assertion macros for the windowed peak-to-peak alarm unit
// included by files that carry concurrent checks; no other dependencies
`ifndef WINDOWED_PEAK_TO_PEAK_ALARM_UNIT_MACROS_SVH
`define WINDOWED_PEAK_TO_PEAK_ALARM_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define WPPA_ASSERT_IMPLY(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("wppa check failed: same-cycle implication");
`define WPPA_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("wppa check failed: next-cycle implication");
`else
`define WPPA_ASSERT_IMPLY(lbl, clk_s, rst_n_s, ante, cons)
`define WPPA_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons)
`endif
`endif

// ===== rtl/wppa_pkg.sv =====
// shared types and constants for the windowed peak-to-peak alarm unit
// no dependencies; imported by every module of the block
package wppa_pkg;

	localparam int SAMPLE_W   = 12;
	localparam int TIME_W     = 32;
	localparam int IVL_W      = 16;
	localparam int SAMPLE_MAX = 4095;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// shared divider: numerator covers 12b x 16b products and window sums
	localparam int DIV_NUM_W = 28;
	localparam int DIV_DEN_W = 12;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

	// signed width of the unclamped mapped interval
	localparam int MAP_W = DIV_NUM_W + 2;

	localparam int Q_DEPTH = 2;

	localparam logic [SAMPLE_W-1:0] THR_RST  = 12'd400;
	localparam logic [SAMPLE_W-1:0] FULL_RST = 12'd4000;
	localparam logic [IVL_W-1:0]    SLOW_RST = 16'd500;
	localparam logic [IVL_W-1:0]    FAST_RST = 16'd30;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ALERT_THR = 2'd0,
		CFG_FULL_INT  = 2'd1,
		CFG_SLOW_IVL  = 2'd2,
		CFG_FAST_IVL  = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] alert_threshold;
		logic [SAMPLE_W-1:0] full_intensity;
		logic [IVL_W-1:0]    slow_interval_ms;
		logic [IVL_W-1:0]    fast_interval_ms;
	} cfg_t;

	// sample in the low bits
	typedef struct packed {
		logic [TIME_W-1:0]   now_ms;
		logic [SAMPLE_W-1:0] sample;
	} in_item_t;

	// window_min in the low bits
	typedef struct packed {
		logic [IVL_W-1:0]    beep_interval_ms;
		logic                beep;
		logic                alert;
		logic [SAMPLE_W-1:0] average;
		logic [SAMPLE_W-1:0] peak_to_peak;
		logic [SAMPLE_W-1:0] window_max;
		logic [SAMPLE_W-1:0] window_min;
	} result_t;

	localparam int IN_TDATA_W  = (($bits(in_item_t) + 7) / 8) * 8;
	localparam int OUT_TDATA_W = (($bits(result_t) + 7) / 8) * 8;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WRITE,
		ST_SCAN,
		ST_AVG_WAIT,
		ST_MAP_MUL,
		ST_MAP_DIV,
		ST_MAP_WAIT,
		ST_CLAMP,
		ST_FINISH
	} back_state_t;

endpackage

// ===== rtl/wppa_fifo.sv =====
// short item queue between the input side and the window engine
// depends on wppa_pkg for the item type and depth
module wppa_fifo
	import wppa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_ready,
	input  in_item_t push_data,
	input  logic     pop,
	output logic     empty,
	output in_item_t pop_data
);

	localparam int PTR_W = $clog2(Q_DEPTH);
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	in_item_t         entries_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;

	assign push_ready = (count_q != CNT_W'(Q_DEPTH));
	assign empty      = (count_q == '0);
	assign push       = push_valid && push_ready;
	assign pop_data   = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			priority if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/wppa_div.sv =====
// restoring unsigned divider, one quotient bit per cycle
// depends on wppa_pkg for widths and the request struct
module wppa_div
	import wppa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  div_req_t             req,
	output logic                 busy,
	output logic [DIV_NUM_W-1:0] quot
);

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W:0]   rem_shift;
	logic [DIV_DEN_W:0]   rem_trial;
	logic                 fits;

	assign busy = busy_q;
	assign quot = quo_q;

	assign rem_shift = {rem_q, quo_q[DIV_NUM_W-1]};
	assign rem_trial = rem_shift - {1'b0, den_q};
	assign fits      = (rem_shift >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(DIV_NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// numerator shifts out at the top while quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
			rem_q <= fits ? rem_trial[DIV_DEN_W-1:0] : rem_shift[DIV_DEN_W-1:0];
		end
	end

endmodule

// ===== rtl/wppa_back.sv =====
// window engine: circular sample memory, min/max scan, average, interval map, beep
// depends on wppa_pkg and instantiates wppa_div
module wppa_back
	import wppa_pkg::*;
#(
	parameter int WINDOW_LEN = 240
) (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     q_empty,
	input  in_item_t q_data,
	output logic     q_pop,
	output logic     out_valid,
	input  logic     out_ready,
	output result_t  out_data
);

	localparam int PTR_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int CNT_W = $clog2(WINDOW_LEN + 1);
	localparam int SUM_W = $clog2(WINDOW_LEN * SAMPLE_MAX + 1);

	back_state_t state_q, state_d;

	logic [SAMPLE_W-1:0] mem [WINDOW_LEN];
	logic [SAMPLE_W-1:0] rdata_q;
	logic [PTR_W-1:0]    mem_raddr;
	logic                mem_we;

	in_item_t            item_q;
	logic [PTR_W-1:0]    pos_q;
	logic [CNT_W-1:0]    fill_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SUM_W-1:0]    sum_new;
	logic [TIME_W-1:0]   last_beep_q;
	logic [CNT_W-1:0]    scan_addr_q;
	logic                scan_live;
	logic                rd_vld_s1;
	logic [PTR_W-1:0]    rd_idx_s1;
	logic [SAMPLE_W-1:0] old_val;
	logic [SAMPLE_W-1:0] scan_val;
	logic [SAMPLE_W-1:0] lo_q;
	logic [SAMPLE_W-1:0] hi_q;
	logic [SAMPLE_W-1:0] p2p;
	logic [SAMPLE_W-1:0] avg_q;
	logic                alert_q;
	logic                eq_q;
	logic                neg_q;
	logic [DIV_NUM_W-1:0] prod_q;
	logic [IVL_W-1:0]    ivl_q;
	logic                out_valid_q;
	result_t             out_data_q;

	logic [SAMPLE_W-1:0] thr_gap;
	logic [IVL_W-1:0]    ivl_span;
	logic [DIV_DEN_W-1:0] map_den;
	logic [MAP_W-1:0]    q_ext;
	logic signed [MAP_W-1:0] m_val;
	logic signed [MAP_W-1:0] fast_s;
	logic signed [MAP_W-1:0] slow_s;
	logic [TIME_W-1:0]   elapsed;
	logic                beep_c;
	logic                out_load;

	div_req_t             div_req;
	logic                 div_busy;
	logic [DIV_NUM_W-1:0] div_quot;

	wppa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	// entries at or beyond the fill count were never written and read as zero
	assign old_val   = (CNT_W'(pos_q) < fill_q) ? rdata_q : '0;
	assign scan_val  = (CNT_W'(rd_idx_s1) < fill_q) ? rdata_q : '0;
	assign sum_new   = sum_q - SUM_W'(old_val) + SUM_W'(item_q.sample);
	assign scan_live = (scan_addr_q < CNT_W'(WINDOW_LEN));
	assign mem_raddr = (state_q == ST_SCAN && scan_live) ? scan_addr_q[PTR_W-1:0] : pos_q;
	assign p2p       = hi_q - lo_q;

	assign thr_gap  = p2p - cfg.alert_threshold;
	assign ivl_span = (cfg.fast_interval_ms >= cfg.slow_interval_ms)
		? cfg.fast_interval_ms - cfg.slow_interval_ms
		: cfg.slow_interval_ms - cfg.fast_interval_ms;
	assign map_den  = (cfg.full_intensity >= cfg.alert_threshold)
		? cfg.full_intensity - cfg.alert_threshold
		: cfg.alert_threshold - cfg.full_intensity;

	// quotient truncates toward zero, sign applied after the unsigned divide
	assign q_ext  = eq_q ? '0 : MAP_W'(div_quot);
	assign fast_s = $signed(MAP_W'(cfg.fast_interval_ms));
	assign slow_s = $signed(MAP_W'(cfg.slow_interval_ms));
	assign m_val  = $signed(neg_q ? (~q_ext + 1'b1) : q_ext) + slow_s;

	assign elapsed  = item_q.now_ms - last_beep_q;
	assign beep_c   = alert_q && (elapsed > TIME_W'(ivl_q));
	assign out_load = (state_q == ST_FINISH) && (!out_valid_q || out_ready);

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		q_pop       = 1'b0;
		mem_we      = 1'b0;
		div_req     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				mem_we        = 1'b1;
				div_req.start = 1'b1;
				div_req.num   = DIV_NUM_W'(sum_new);
				div_req.den   = DIV_DEN_W'(WINDOW_LEN);
				state_d       = ST_SCAN;
			end
			ST_SCAN: begin
				if (!scan_live && rd_vld_s1) begin
					state_d = ST_AVG_WAIT;
				end
			end
			ST_AVG_WAIT: begin
				if (!div_busy) begin
					state_d = ST_MAP_MUL;
				end
			end
			ST_MAP_MUL: begin
				state_d = (p2p > cfg.alert_threshold) ? ST_MAP_DIV : ST_FINISH;
			end
			ST_MAP_DIV: begin
				if (eq_q) begin
					state_d = ST_CLAMP;
				end else begin
					div_req.start = 1'b1;
					div_req.num   = prod_q;
					div_req.den   = map_den;
					state_d       = ST_MAP_WAIT;
				end
			end
			ST_MAP_WAIT: begin
				if (!div_busy) begin
					state_d = ST_CLAMP;
				end
			end
			ST_CLAMP: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			fill_q      <= '0;
			sum_q       <= '0;
			last_beep_q <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN) && scan_live;
			if (state_q == ST_WRITE) begin
				sum_q  <= sum_new;
				pos_q  <= (pos_q == PTR_W'(WINDOW_LEN - 1)) ? '0 : pos_q + 1'b1;
				if (fill_q != CNT_W'(WINDOW_LEN)) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (out_load && beep_c) begin
				last_beep_q <= item_q.now_ms;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[pos_q] <= item_q.sample;
		end
		rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_data;
		end
		if (state_q == ST_WRITE) begin
			lo_q        <= SAMPLE_W'(SAMPLE_MAX);
			hi_q        <= '0;
			scan_addr_q <= '0;
		end
		if (state_q == ST_SCAN) begin
			if (scan_live) begin
				scan_addr_q <= scan_addr_q + 1'b1;
			end
			rd_idx_s1 <= scan_addr_q[PTR_W-1:0];
			if (rd_vld_s1) begin
				if (scan_val < lo_q) begin
					lo_q <= scan_val;
				end
				if (scan_val > hi_q) begin
					hi_q <= scan_val;
				end
			end
		end
		if (state_q == ST_AVG_WAIT && !div_busy) begin
			avg_q <= div_quot[SAMPLE_W-1:0];
		end
		if (state_q == ST_MAP_MUL) begin
			alert_q <= (p2p > cfg.alert_threshold);
			eq_q    <= (cfg.full_intensity == cfg.alert_threshold);
			neg_q   <= (cfg.fast_interval_ms < cfg.slow_interval_ms)
				^ (cfg.full_intensity < cfg.alert_threshold);
			prod_q  <= DIV_NUM_W'(thr_gap * ivl_span);
			ivl_q   <= '0;
		end
		if (state_q == ST_CLAMP) begin
			priority if (m_val < fast_s) begin
				ivl_q <= cfg.fast_interval_ms;
			end else if (m_val > slow_s) begin
				ivl_q <= cfg.slow_interval_ms;
			end else begin
				ivl_q <= m_val[IVL_W-1:0];
			end
		end
		if (out_load) begin
			out_data_q.window_min       <= lo_q;
			out_data_q.window_max       <= hi_q;
			out_data_q.peak_to_peak     <= p2p;
			out_data_q.average          <= avg_q;
			out_data_q.alert            <= alert_q;
			out_data_q.beep             <= beep_c;
			out_data_q.beep_interval_ms <= ivl_q;
		end
	end

endmodule

// ===== rtl/windowed_peak_to_peak_alarm_unit.sv =====
// the engine takes one item at a time: the next leaves the queue only after the last result
// is loaded into the output register; the work is the one-entry-a-cycle min/max walk over
// the window memory, the average divide on the shared divider and, for items with alert, the interval map
// a two-item queue takes input while the engine works; one output register holds the result
// reset: registers to defaults, window reads as zero through a fill count, no clearing pass
module windowed_peak_to_peak_alarm_unit
	import wppa_pkg::*;
#(
	parameter int WINDOW_LEN = 240
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// sample[11:0], now_ms[43:12], zero fill
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// window_min[11:0], window_max[23:12], peak_to_peak[35:24], average[47:36],
	// alert[48], beep[49], beep_interval_ms[65:50], zero fill
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

`include "windowed_peak_to_peak_alarm_unit_macros.svh"

	cfg_t     cfg_q;
	in_item_t in_item;
	in_item_t q_data;
	logic     q_empty;
	logic     q_pop;
	result_t  res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alert_threshold  <= THR_RST;
			cfg_q.full_intensity   <= FULL_RST;
			cfg_q.slow_interval_ms <= SLOW_RST;
			cfg_q.fast_interval_ms <= FAST_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ALERT_THR: cfg_q.alert_threshold  <= cfg_data[SAMPLE_W-1:0];
				CFG_FULL_INT:  cfg_q.full_intensity   <= cfg_data[SAMPLE_W-1:0];
				CFG_SLOW_IVL:  cfg_q.slow_interval_ms <= cfg_data[IVL_W-1:0];
				CFG_FAST_IVL:  cfg_q.fast_interval_ms <= cfg_data[IVL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign in_item = in_item_t'(s_axis_tdata[$bits(in_item_t)-1:0]);

	wppa_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (s_axis_tvalid),
		.push_ready (s_axis_tready),
		.push_data  (in_item),
		.pop        (q_pop),
		.empty      (q_empty),
		.pop_data   (q_data)
	);

	wppa_back #(
		.WINDOW_LEN (WINDOW_LEN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (res)
	);

	assign m_axis_tdata = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, res};

	`WPPA_ASSERT_IMPLY(a_pop_nonempty, clk, arst_n, q_pop, !q_empty)
	`WPPA_ASSERT_NEXT(a_one_item_at_a_time, clk, arst_n, q_pop, !q_pop)
	`WPPA_ASSERT_IMPLY(a_quiet_without_alert, clk, arst_n, m_axis_tvalid && !res.alert, !res.beep && res.beep_interval_ms == '0)
	`WPPA_ASSERT_IMPLY(a_p2p_consistent, clk, arst_n, m_axis_tvalid, res.window_min <= res.window_max && res.peak_to_peak == res.window_max - res.window_min)

endmodule

// ===== dv/tb_top.sv =====
// testbench for the windowed peak-to-peak alarm unit: stream driver, output checker and
// a cycle-free predictor of the window statistics and beep timing
// depends on wppa_pkg and windowed_peak_to_peak_alarm_unit
`timescale 1ns / 1ps

module tb_top;
	import wppa_pkg::*;

	localparam int WIN_LEN = 240;
	localparam int STALL_LIMIT = 20000;
	localparam int LONG_HOLD = 4000;
	localparam int SETTLE_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	cfg_idx_t cfg_index = CFG_ALERT_THR;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	// predictor state: window contents, write slot, running sum, time of the last beep
	logic [SAMPLE_W-1:0] win_mem [WIN_LEN];
	int unsigned win_pos;
	logic [19:0] win_sum;
	logic [TIME_W-1:0] beep_mark;
	logic [IVL_W-1:0] last_ivl;
	cfg_t cfg_shadow;

	in_item_t sample_backlog [$];
	result_t expected_stats [$];

	int items_in = 0;
	int results_out = 0;
	int beeps_seen = 0;
	int alerts_seen = 0;
	int reg_writes = 0;
	int mismatches = 0;
	int src_idle = 0;
	int snk_idle = 0;
	int src_idle_pct = 20;
	int snk_idle_pct = 20;
	int hold_left = 0;
	logic hold_done = 1'b0;
	int stall_cycles = 0;

	windowed_peak_to_peak_alarm_unit #(
		.WINDOW_LEN(WIN_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// write one sample into the window and work out the statistics and beep decision
	function automatic result_t predict_window_stats(input in_item_t smp);
		result_t res;
		logic [SAMPLE_W-1:0] lo;
		logic [SAMPLE_W-1:0] hi;
		logic [SAMPLE_W-1:0] span;
		logic [TIME_W-1:0] elapsed;
		longint thr, full, slow, fast, ivl;
		lo = '1;
		hi = '0;
		res = '0;
		win_sum = win_sum - win_mem[win_pos] + smp.sample;
		win_mem[win_pos] = smp.sample;
		win_pos = (win_pos == WIN_LEN - 1) ? 0 : win_pos + 1;
		foreach (win_mem[i]) begin
			if (win_mem[i] > hi)
				hi = win_mem[i];
			if (win_mem[i] < lo)
				lo = win_mem[i];
		end
		span = hi - lo;
		res.window_min = lo;
		res.window_max = hi;
		res.peak_to_peak = span;
		res.average = win_sum / WIN_LEN;
		res.alert = span > cfg_shadow.alert_threshold;
		if (res.alert) begin
			thr = cfg_shadow.alert_threshold;
			full = cfg_shadow.full_intensity;
			slow = cfg_shadow.slow_interval_ms;
			fast = cfg_shadow.fast_interval_ms;
			ivl = span;
			// signed map, division truncates toward zero
			if (full == thr)
				ivl = slow;
			else
				ivl = (ivl - thr) * (fast - slow) / (full - thr) + slow;
			if (ivl < fast)
				ivl = fast;
			else if (ivl > slow)
				ivl = slow;
			res.beep_interval_ms = ivl[IVL_W-1:0];
			elapsed = smp.now_ms - beep_mark;
			if (elapsed > res.beep_interval_ms) begin
				res.beep = 1'b1;
				beep_mark = smp.now_ms;
			end
		end
		last_ivl = res.beep_interval_ms;
		return res;
	endfunction

	task automatic note_mismatch(input string what, input longint unsigned want,
			input longint unsigned got);
		if (mismatches < 10)
			$display("mismatch on %0s at result %0d: expected %0d, got %0d",
				what, results_out, want, got);
		mismatches++;
	endtask

	// input driver: offers the backlog, inserts idle bursts after an item
	always @(posedge clk) begin : drive_items
		result_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				want = predict_window_stats(s_axis_tdata[$bits(in_item_t)-1:0]);
				expected_stats.push_back(want);
				items_in <= items_in + 1;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (src_idle > 0) begin
					src_idle <= src_idle - 1;
					s_axis_tvalid <= 1'b0;
				end else if (sample_backlog.size() > 0) begin
					s_axis_tdata <= {{(IN_TDATA_W - $bits(in_item_t)){1'b0}},
						sample_backlog.pop_front()};
					s_axis_tvalid <= 1'b1;
					if ($urandom_range(99) < src_idle_pct)
						src_idle <= $urandom_range(1, 12);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// one long receiver hold-off once the run is well under way
	always @(posedge clk) begin
		if (arst_n) begin
			if (!hold_done && items_in >= 300) begin
				hold_left <= LONG_HOLD;
				hold_done <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
			end
		end
	end

	// output monitor and receiver backpressure
	always @(posedge clk) begin : check_results
		result_t got;
		result_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[$bits(result_t)-1:0];
				if (expected_stats.size() == 0) begin
					note_mismatch("result with nothing pending", 0, 0);
				end else begin
					want = expected_stats.pop_front();
					if (got.window_min !== want.window_min)
						note_mismatch("window_min", want.window_min, got.window_min);
					if (got.window_max !== want.window_max)
						note_mismatch("window_max", want.window_max, got.window_max);
					if (got.peak_to_peak !== want.peak_to_peak)
						note_mismatch("peak_to_peak", want.peak_to_peak, got.peak_to_peak);
					if (got.average !== want.average)
						note_mismatch("average", want.average, got.average);
					if (got.alert !== want.alert)
						note_mismatch("alert", want.alert, got.alert);
					if (got.beep !== want.beep)
						note_mismatch("beep", want.beep, got.beep);
					if (got.beep_interval_ms !== want.beep_interval_ms)
						note_mismatch("beep_interval_ms", want.beep_interval_ms,
							got.beep_interval_ms);
					if (want.beep)
						beeps_seen++;
					if (want.alert)
						alerts_seen++;
				end
				results_out <= results_out + 1;
			end
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
			end else if (snk_idle > 0) begin
				snk_idle <= snk_idle - 1;
				m_axis_tready <= 1'b0;
			end else if ($urandom_range(99) < snk_idle_pct) begin
				snk_idle <= $urandom_range(0, 11);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout: no transfer for %0d cycles, %0d results still pending",
				stall_cycles, expected_stats.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic wait_all_results(input int settle);
		while (sample_backlog.size() != 0 || s_axis_tvalid || expected_stats.size() != 0)
			@(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_ALERT_THR: cfg_shadow.alert_threshold = val[SAMPLE_W-1:0];
			CFG_FULL_INT:  cfg_shadow.full_intensity = val[SAMPLE_W-1:0];
			CFG_SLOW_IVL:  cfg_shadow.slow_interval_ms = val;
			CFG_FAST_IVL:  cfg_shadow.fast_interval_ms = val;
			default: ;
		endcase
		reg_writes++;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input logic [15:0] thr, input logic [15:0] full,
			input logic [15:0] slow, input logic [15:0] fast);
		wait_all_results(8);
		write_reg(CFG_ALERT_THR, thr);
		write_reg(CFG_FULL_INT, full);
		write_reg(CFG_SLOW_IVL, slow);
		write_reg(CFG_FAST_IVL, fast);
		@(negedge clk);
	endtask

	// one item on its own, so the next one can be aimed at the beep boundary
	task automatic send_one(input logic [SAMPLE_W-1:0] s, input logic [TIME_W-1:0] t);
		in_item_t smp;
		smp.sample = s;
		smp.now_ms = t;
		sample_backlog.push_back(smp);
		wait_all_results(0);
	endtask

	initial begin : stimulus
		in_item_t smp;
		int bands [5];
		int ph, k, band, base, sel, t;
		logic [TIME_W-1:0] clock_ms;
		bands = '{40, 400, 1200, 2600, 4095};
		foreach (win_mem[i])
			win_mem[i] = '0;
		win_pos = 0;
		win_sum = '0;
		beep_mark = '0;
		last_ivl = '0;
		cfg_shadow.alert_threshold = THR_RST;
		cfg_shadow.full_intensity = FULL_RST;
		cfg_shadow.slow_interval_ms = SLOW_RST;
		cfg_shadow.fast_interval_ms = FAST_RST;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// window all zero: no alert
		send_one(12'd0, 32'd0);
		// one full-scale entry: alert, map falls below fast and clamps
		send_one(12'hFFF, 32'd5);
		// elapsed equal to the interval gives no beep, one more gives a beep
		send_one(12'hFFF, beep_mark + last_ivl);
		send_one(12'hFFF, beep_mark + last_ivl + 1);
		send_one(12'd2048, 32'hFFFF_FFFF);
		// elapsed time wraps through zero
		send_one(12'd1, 32'd20);
		send_one(12'd1, 32'd40);
		// full intensity equal to threshold: slow interval
		set_config(16'd1000, 16'd1000, 16'd700, 16'd30);
		send_one(12'd3000, beep_mark + 700);
		send_one(12'd3000, beep_mark + 701);
		// fast above slow
		set_config(16'd400, 16'd4000, 16'd100, 16'd900);
		send_one(12'd4095, beep_mark + 101);
		// full below threshold: negative denominator
		set_config(16'd3000, 16'd1000, 16'd2000, 16'd20);
		send_one(12'd0, beep_mark + 2001);
		// register extremes
		set_config(16'd0, 16'd4095, 16'hFFFF, 16'd0);
		send_one(12'd4095, beep_mark + 32'd12345);
		send_one(12'h555, beep_mark + 32'h8000_0000);
		set_config(16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
		send_one(12'hAAA, 32'hFFFF_FFFF);

		clock_ms = $urandom;
		for (ph = 0; ph < 10; ph++) begin
			case (ph)
				0: set_config(THR_RST, FULL_RST, SLOW_RST, FAST_RST);
				1: set_config(16'd0, 16'd4095, 16'hFFFF, 16'd0);
				2: set_config(16'd4095, 16'd0, 16'd0, 16'hFFFF);
				3: begin
					t = $urandom_range(0, 4095);
					set_config(t, t, $urandom_range(0, 65535), $urandom_range(0, 65535));
				end
				4: begin
					t = $urandom_range(0, 2000);
					set_config($urandom_range(0, 1500), $urandom_range(0, 4095), t,
						t + $urandom_range(1, 3000));
				end
				5: begin
					t = $urandom_range(1500, 3000);
					set_config(t, $urandom_range(0, t - 1), $urandom_range(0, 5000),
						$urandom_range(0, 200));
				end
				default: set_config({4'($urandom), 12'($urandom_range(0, 2500))},
					{4'($urandom), 12'($urandom)}, $urandom_range(0, 65535),
					$urandom_range(0, 2000));
			endcase
			// push the time stamp just below the 32-bit wrap
			if (ph == 6)
				clock_ms = 32'hFFFF_FF00;
			band = bands[ph % 5];
			for (k = 0; k < 93; k++) begin
				if (k % 31 == 0) begin
					while (sample_backlog.size() > 2)
						@(negedge clk);
					base = $urandom_range(0, 4095 - band);
					if (ph == 9) begin
						src_idle_pct = 0;
						snk_idle_pct = 0;
					end else begin
						sel = $urandom_range(0, 2);
						src_idle_pct = (sel == 0) ? 0 : (sel == 1) ? 10 : 35;
						sel = $urandom_range(0, 2);
						snk_idle_pct = (sel == 0) ? 0 : (sel == 1) ? 10 : 35;
					end
				end
				// mostly samples in a drifting band, a few spikes anywhere
				if ($urandom_range(99) < 5)
					smp.sample = $urandom;
				else
					smp.sample = base + $urandom_range(0, band);
				sel = $urandom_range(99);
				if (sel < 70)
					clock_ms = clock_ms + $urandom_range(0, 40);
				else if (sel < 90)
					clock_ms = clock_ms + $urandom_range(0, 1500);
				else if (sel < 97)
					clock_ms = clock_ms + $urandom_range(0, 70000);
				else
					clock_ms = $urandom;
				smp.now_ms = clock_ms;
				sample_backlog.push_back(smp);
			end
		end

		wait_all_results(SETTLE_CYCLES);
		$display("%0d items in, %0d results checked, %0d register writes",
			items_in, results_out, reg_writes);
		$display("%0d results with alert, %0d with beep, %0d mismatches",
			alerts_seen, beeps_seen, mismatches);
		if (mismatches == 0 && expected_stats.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
